// ===== rtl/tccs_pkg.sv =====
`default_nettype none
package tccs_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_CNT   = CELL_COUNT - COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  // field widths
  localparam int FUNC_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IN_ADDR_W = 11;
  localparam int CELL_W    = 16;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_COPY,
    OP_BLANK
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic put_scroll;
    logic copy_end;
    logic sweep_end;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/tccs_if.sv =====
`default_nettype none
interface tccs_in_if;
  import tccs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [CHAR_W-1:0]    char_code;
  logic [IN_ADDR_W-1:0] cell_address;

  modport source (output valid, func, char_code, cell_address, input ready);
  modport sink (input valid, func, char_code, cell_address, output ready);
endinterface

interface tccs_out_if;
  import tccs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CELL_W-1:0]    cell_data;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [OUT_COL_W-1:0] cursor_col;
  logic                 scrolled;

  modport source (output valid, cell_data, cursor_row, cursor_col, scrolled, input ready);
  modport sink (input valid, cell_data, cursor_row, cursor_col, scrolled, output ready);
endinterface

interface tccs_cfg_if;
  import tccs_pkg::*;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tccs_ram.sv =====
`default_nettype none
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tccs_ctrl.sv =====
`default_nettype none
module tccs_ctrl
  import tccs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  tccs_in_if.sink         in_ch,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    in_ch.ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.op = OP_INIT;
        if (st.sweep_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd.op = OP_ACCEPT;
          if (in_ch.func == FUNC_CLEAR) begin
            state_nxt = ST_BLANK;
          end else if (in_ch.func == FUNC_PUT && st.put_scroll) begin
            state_nxt = ST_COPY;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_COPY: begin
        cmd.op = OP_COPY;
        if (st.copy_end) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.op = OP_BLANK;
        if (st.sweep_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // one item at a time: an accepted item is answered before the next is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again before result was loaded");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over a pending result");

  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COPY || cmd.op == OP_BLANK || cmd.op == OP_INIT) |-> !cmd.load_out)
    else $error("result loaded while a sweep is running");

endmodule
`default_nettype wire

// ===== rtl/tccs_datapath.sv =====
`default_nettype none
module tccs_datapath
  import tccs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic [IN_ADDR_W-1:0] in_cell_address,
  tccs_cfg_if.sink                  cfg_ch,
  tccs_out_if.source                out_ch,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                st
);

  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              is_read_r, is_read_nxt;
  logic              out_valid_r;
  logic [CELL_W-1:0] out_data_r;
  logic              out_scrolled_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              last_row, wrap, rd_ok;
  logic [ADDR_W-1:0] cursor_idx;

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign last_row   = (cur_row_r == ROW_W'(ROWS - 1));
  assign wrap       = (in_char_code == NEWLINE_CODE) || (cur_col_r == COL_W'(COLUMNS - 1));
  assign rd_ok      = (32'(in_cell_address) < CELL_COUNT);
  assign cursor_idx = ADDR_W'(cur_row_r) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_r);

  assign st.put_scroll = wrap && last_row;
  assign st.copy_end   = (cnt_r == ADDR_W'(COPY_CNT));
  assign st.sweep_end  = (cnt_r == ADDR_W'(CELL_COUNT - 1));
  assign st.out_free   = !out_valid_r || out_ch.ready;

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = {attr_r, BLANK_CHAR};
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(in_cell_address);
    case (cmd.op)
      OP_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {RESET_ATTR, BLANK_CHAR};
      end
      OP_ACCEPT: begin
        if (in_func == FUNC_PUT && in_char_code != NEWLINE_CODE) begin
          ram_we    = 1'b1;
          ram_waddr = cursor_idx;
          ram_wdata = {attr_r, in_char_code};
        end
        ram_re = (in_func == FUNC_READ) && rd_ok;
      end
      OP_COPY: begin
        // read one row ahead, write the cell fetched in the previous cycle
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - ADDR_W'(1);
        ram_wdata = ram_rdata;
        ram_re    = !st.copy_end;
        ram_raddr = cnt_r + ADDR_W'(COLUMNS);
      end
      OP_BLANK: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // cursor and sweep counter
  always_comb begin
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cnt_nxt      = cnt_r;
    scrolled_nxt = scrolled_r;
    is_read_nxt  = is_read_r;
    case (cmd.op)
      OP_INIT, OP_BLANK: begin
        cnt_nxt = st.sweep_end ? '0 : cnt_r + ADDR_W'(1);
      end
      OP_COPY: begin
        cnt_nxt = st.copy_end ? cnt_r : cnt_r + ADDR_W'(1);
      end
      OP_ACCEPT: begin
        cnt_nxt      = '0;
        scrolled_nxt = 1'b0;
        is_read_nxt  = (in_func == FUNC_READ) && rd_ok;
        if (in_func == FUNC_PUT) begin
          if (wrap) begin
            cur_col_nxt  = '0;
            cur_row_nxt  = last_row ? cur_row_r : cur_row_r + ROW_W'(1);
            scrolled_nxt = last_row;
          end else begin
            cur_col_nxt = cur_col_r + COL_W'(1);
          end
        end else if (in_func == FUNC_CLEAR) begin
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      attr_r      <= RESET_ATTR;
      cnt_r       <= '0;
      scrolled_r  <= 1'b0;
      is_read_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      cnt_r      <= cnt_nxt;
      scrolled_r <= scrolled_nxt;
      is_read_r  <= is_read_nxt;
      if (cfg_ch.valid) begin
        attr_r <= cfg_ch.data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r     <= is_read_r ? ram_rdata : '0;
      out_row_r      <= cur_row_r;
      out_col_r      <= cur_col_r;
      out_scrolled_r <= scrolled_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_data  = out_data_r;
  assign out_ch.cursor_row = OUT_ROW_W'(out_row_r);
  assign out_ch.cursor_col = OUT_COL_W'(out_col_r);
  assign out_ch.scrolled   = out_scrolled_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < ROWS && 32'(cur_col_r) < COLUMNS)
    else $error("cursor left the screen");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re && cmd.op == OP_COPY |-> ram_waddr < ram_raddr)
    else $error("scroll copy writes ahead of its reads");

  a_copy_then_blank: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_COPY && st.copy_end |=> cnt_r == ADDR_W'(COPY_CNT))
    else $error("bottom row blanking does not start at the last row");

endmodule
`default_nettype wire

// ===== rtl/text_console_cursor_scroll_unit.sv =====
// channel   dir  handshake    payload
// in_ch     in   valid/ready  func, char_code, cell_address
// out_ch    out  valid/ready  cell_data, cursor_row, cursor_col, scrolled
// cfg_ch    in   valid/ready  data (attribute byte, ready always high)
//
// put, read and unused codes go through accept, then load of the output register
// a put that scrolls adds a copy pass that moves every row up by one and a blank pass over the bottom row
// a clear adds a blank pass over all CELL_COUNT cells; both are paced by the single screen ram write port
// after reset a pass over all CELL_COUNT cells (2000) writes blanks before the first item is taken
// a stalled output keeps the controller in its result state with the input not ready
// cfg writes are taken any time
`default_nettype none
module text_console_cursor_scroll_unit
  import tccs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  tccs_in_if.sink    in_ch,
  tccs_out_if.source out_ch,
  tccs_cfg_if.sink   cfg_ch
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencer: init sweep, accept, scroll copy, blanking, result hand-off
  tccs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .st    (st),
    .cmd   (cmd)
  );

  // cursor, attribute, screen ram and output register
  tccs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_ch.func),
    .in_char_code    (in_ch.char_code),
    .in_cell_address (in_ch.cell_address),
    .cfg_ch          (cfg_ch),
    .out_ch          (out_ch),
    .cmd             (cmd),
    .st              (st)
  );

endmodule
`default_nettype wire
